>>> rtl/core/mmws_pkg.sv
// Shared types and constants for the market message window scanner.
package mmws_pkg;

    localparam int WIN_LEN    = 36;
    localparam int FILL_W     = 6;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int TDATA_W    = 280;

    localparam logic [7:0] TYPE_TRADE    = 8'h54;
    localparam logic [7:0] TYPE_QUOTE    = 8'h51;
    localparam logic [7:0] TYPE_OFFICIAL = 8'h58;
    localparam logic [7:0] PRINT_LO      = 8'h20;
    localparam logic [7:0] PRINT_HI      = 8'h7E;
    localparam logic [7:0] CHAR_A        = 8'h41;
    localparam logic [7:0] CHAR_Z        = 8'h5A;

    localparam logic [1:0] KIND_TRADE    = 2'd0;
    localparam logic [1:0] KIND_QUOTE    = 2'd1;
    localparam logic [1:0] KIND_OFFICIAL = 2'd2;
    localparam logic [1:0] KIND_SUMMARY  = 2'd3;

    localparam logic [2:0] REG_TRADE_CAP    = 3'd0;
    localparam logic [2:0] REG_QUOTE_CAP    = 3'd1;
    localparam logic [2:0] REG_OFFICIAL_CAP = 3'd2;
    localparam logic [2:0] REG_MIN_PRICE    = 3'd3;
    localparam logic [2:0] REG_MAX_PRICE    = 3'd4;

    typedef logic [WIN_LEN-1:0][7:0] win_t;   // entry 0 is the oldest byte

    typedef struct packed {
        logic valid;
        logic full;       // 36 bytes of this packet are in the window
        logic pkt_end;
    } stage_t;

    typedef struct packed {
        logic [3:0]  trade_cap;
        logic [3:0]  quote_cap;
        logic [3:0]  official_cap;
        logic [31:0] min_price;
        logic [31:0] max_price;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] stamp;
        logic [63:0] ticker;
        logic [31:0] price_a;
        logic [31:0] size_a;
        logic [31:0] price_b;
        logic [31:0] size_b;
        logic [7:0]  condition;
        logic [3:0]  trades_seen;
        logic [3:0]  quotes_seen;
        logic [3:0]  officials_seen;
        logic        last;
    } res_t;

endpackage

>>> rtl/core/mmws_window.sv
// Input side: 36-byte sliding window register and packet fill count.
module mmws_window (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_accept,
    input  logic [7:0]     in_byte,
    input  logic           in_end,
    output mmws_pkg::win_t win,
    output mmws_pkg::stage_t stage
);

    mmws_pkg::win_t   win_reg, win_next;
    mmws_pkg::stage_t stage_reg, stage_next;
    logic [mmws_pkg::FILL_W-1:0] fill_reg, fill_next, fill_inc;

    // The window is never cleared: a check needs a full window, and by then
    // every byte in it belongs to the current packet.
    always_comb begin
        fill_inc = (fill_reg == mmws_pkg::FILL_W'(mmws_pkg::WIN_LEN)) ?
                   fill_reg : fill_reg + 1'b1;
        win_next   = win_reg;
        fill_next  = fill_reg;
        stage_next = '0;
        if (in_accept) begin
            for (int i = 0; i < mmws_pkg::WIN_LEN - 1; i++) begin
                win_next[i] = win_reg[i+1];
            end
            win_next[mmws_pkg::WIN_LEN-1] = in_byte;
            fill_next          = in_end ? '0 : fill_inc;
            stage_next.valid   = 1'b1;
            stage_next.full    = (fill_inc == mmws_pkg::FILL_W'(mmws_pkg::WIN_LEN));
            stage_next.pkt_end = in_end;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
        if (!aresetn) begin
            fill_reg  <= '0;
            stage_reg <= '0;
        end else begin
            fill_reg  <= fill_next;
            stage_reg <= stage_next;
        end
    end

    assign win   = win_reg;
    assign stage = stage_reg;

endmodule

>>> rtl/core/mmws_check.sv
// Window check: type decode, per-packet caps, field extraction, price filters.
module mmws_check (
    input  logic             aclk,
    input  logic             aresetn,
    input  mmws_pkg::win_t   win,
    input  mmws_pkg::stage_t stage,
    input  mmws_pkg::cfg_t   cfg,
    output mmws_pkg::res_t   res0,
    output mmws_pkg::res_t   res1,
    output logic [1:0]       push_cnt
);

    logic [3:0] trade_cnt_reg, trade_cnt_next;
    logic [3:0] quote_cnt_reg, quote_cnt_next;
    logic [3:0] official_cnt_reg, official_cnt_next;

    logic        first_ok, is_trade, is_quote, is_official;
    logic        accepted, pass, emit;
    logic [63:0] stamp, ticker;
    logic [31:0] pa, sa, pb, sb;
    logic [7:0]  cond, tb;
    logic [2:0]  pos;
    mmws_pkg::res_t match_res, sum_res;

    always_comb begin
        first_ok    = (win[9] >= mmws_pkg::CHAR_A) && (win[9] <= mmws_pkg::CHAR_Z);
        is_trade    = first_ok && (win[0] == mmws_pkg::TYPE_TRADE);
        is_quote    = first_ok && (win[0] == mmws_pkg::TYPE_QUOTE);
        is_official = first_ok && (win[0] == mmws_pkg::TYPE_OFFICIAL);

        trade_cnt_next    = trade_cnt_reg;
        quote_cnt_next    = quote_cnt_reg;
        official_cnt_next = official_cnt_reg;
        accepted          = 1'b0;
        if (stage.valid && stage.full) begin
            if (is_trade && (trade_cnt_reg < cfg.trade_cap)) begin
                trade_cnt_next = trade_cnt_reg + 1'b1;
                accepted       = 1'b1;
            end
            if (is_quote && (quote_cnt_reg < cfg.quote_cap)) begin
                quote_cnt_next = quote_cnt_reg + 1'b1;
                accepted       = 1'b1;
            end
            if (is_official && (official_cnt_reg < cfg.official_cap)) begin
                official_cnt_next = official_cnt_reg + 1'b1;
                accepted          = 1'b1;
            end
        end

        // Little-endian fields
        for (int i = 0; i < 8; i++) begin
            stamp[8*i +: 8] = win[1+i];
        end
        for (int i = 0; i < 4; i++) begin
            pa[8*i +: 8] = win[17+i];
            sa[8*i +: 8] = win[21+i];
            pb[8*i +: 8] = win[25+i];
            sb[8*i +: 8] = win[29+i];
        end

        // Compact the non-space printable symbol bytes toward bit 0
        ticker = '0;
        pos    = '0;
        for (int k = 0; k < 8; k++) begin
            tb = win[9+k];
            if ((tb > mmws_pkg::PRINT_LO) && (tb <= mmws_pkg::PRINT_HI)) begin
                ticker = ticker | (64'(tb) << {pos, 3'b000});
                pos    = pos + 1'b1;
            end
        end

        cond = ((win[25] >= mmws_pkg::PRINT_LO) && (win[25] <= mmws_pkg::PRINT_HI)) ?
               win[25] : mmws_pkg::PRINT_LO;

        match_res        = '0;
        match_res.stamp  = stamp;
        match_res.ticker = ticker;
        match_res.price_a = pa;
        pass = 1'b0;
        if (is_trade) begin
            pass                = (pa > cfg.min_price) && (pa < cfg.max_price);
            match_res.kind      = mmws_pkg::KIND_TRADE;
            match_res.size_a    = sa;
            match_res.condition = cond;
        end else if (is_quote) begin
            pass = (pa > cfg.min_price) && (pb > cfg.min_price) && (pb > pa);
            match_res.kind    = mmws_pkg::KIND_QUOTE;
            match_res.size_a  = sa;
            match_res.price_b = pb;
            match_res.size_b  = sb;
        end else begin
            pass           = (pa > cfg.min_price);
            match_res.kind = mmws_pkg::KIND_OFFICIAL;
        end
        emit           = accepted && (ticker != '0) && pass;
        match_res.last = !stage.pkt_end;

        sum_res                = '0;
        sum_res.kind           = mmws_pkg::KIND_SUMMARY;
        sum_res.trades_seen    = trade_cnt_next;
        sum_res.quotes_seen    = quote_cnt_next;
        sum_res.officials_seen = official_cnt_next;
        sum_res.last           = 1'b1;

        res0     = emit ? match_res : sum_res;
        res1     = sum_res;
        push_cnt = 2'(emit) + 2'(stage.valid && stage.pkt_end);

        if (stage.valid && stage.pkt_end) begin
            trade_cnt_next    = '0;
            quote_cnt_next    = '0;
            official_cnt_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trade_cnt_reg    <= '0;
            quote_cnt_reg    <= '0;
            official_cnt_reg <= '0;
        end else begin
            trade_cnt_reg    <= trade_cnt_next;
            quote_cnt_reg    <= quote_cnt_next;
            official_cnt_reg <= official_cnt_next;
        end
    end

endmodule

>>> rtl/core/mmws_fifo.sv
// Result queue: takes up to two results per cycle, delivers one.
module mmws_fifo (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  mmws_pkg::res_t               din0,
    input  mmws_pkg::res_t               din1,
    input  logic [1:0]                   push_cnt,
    input  logic                         pop,
    output mmws_pkg::res_t               dout,
    output logic                         not_empty,
    output logic [mmws_pkg::FIFO_AW:0]   level
);

    mmws_pkg::res_t mem_reg [mmws_pkg::FIFO_DEPTH];
    logic [mmws_pkg::FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [mmws_pkg::FIFO_AW-1:0] wr_ptr_p1;
    logic [mmws_pkg::FIFO_AW:0]   count_reg, count_next;

    always_comb begin
        wr_ptr_p1   = wr_ptr_reg + 1'b1;
        wr_ptr_next = wr_ptr_reg + mmws_pkg::FIFO_AW'(push_cnt);
        rd_ptr_next = rd_ptr_reg + mmws_pkg::FIFO_AW'(pop);
        count_next  = count_reg + (mmws_pkg::FIFO_AW + 1)'(push_cnt)
                      - (mmws_pkg::FIFO_AW + 1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem_reg[wr_ptr_reg] <= din0;
        end
        if (push_cnt == 2'd2) begin
            mem_reg[wr_ptr_p1] <= din1;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign dout      = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign level     = count_reg;

endmodule

>>> rtl/core/market_message_window_scanner.sv
// Top level of the market message window scanner.
//
// Payload bytes enter on the s_ channel, one per transaction, with s_tlast on
// the last byte of a UDP payload. Each byte shifts into the 36-byte window of
// the current packet; a full window is checked for trade, quote and official
// price messages. Accepted matches that pass the price filters leave on the
// m_ channel, and the last byte of a packet adds a summary with the packet's
// match counters. m_tlast marks the final result caused by one input byte.
// Configuration registers are written on the cfg_ channel, index 0..4 in the
// order trade cap, quote cap, official cap, min price, max price.
// Each byte's window is registered and checked; its results enter an 8-entry
// result queue. Throughput: one byte per cycle while s_tready is high; a byte
// can cause two results, which drain at one per cycle while m_tready is high.
// s_tready drops while the queue might not hold the results of the byte in
// flight plus two more, so a stalled receiver backs up to the input without
// losing results. Reset (aresetn low, synchronous) empties the queue, clears
// the packet counters and fill count, and loads the register defaults.
module market_message_window_scanner (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // payload_byte
    input  logic         s_tlast,   // packet_end
    output logic         m_tvalid,
    input  logic         m_tready,
    // stamp, ticker, price_a, size_a, price_b, size_b, condition,
    // trades_seen, quotes_seen, officials_seen, zero pad
    output logic [mmws_pkg::TDATA_W-1:0] m_tdata,
    output logic [1:0]   m_tuser,   // kind
    output logic         m_tlast,   // last
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    mmws_pkg::cfg_t   cfg_reg;
    mmws_pkg::win_t   win;
    mmws_pkg::stage_t stage;
    mmws_pkg::res_t   res0, res1, head;
    logic [1:0]       push_cnt;
    logic             in_accept, pop, not_empty;
    logic [mmws_pkg::FIFO_AW:0] level, need;

    // Room for the in-flight byte's results and two more
    always_comb begin
        need     = level + ((mmws_pkg::FIFO_AW + 1)'(stage.valid) << 1) + 2'd2;
        s_tready = (need <= (mmws_pkg::FIFO_AW + 1)'(mmws_pkg::FIFO_DEPTH));
    end

    assign in_accept = s_tvalid && s_tready;
    assign pop       = m_tvalid && m_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.trade_cap    <= 4'd10;
            cfg_reg.quote_cap    <= 4'd5;
            cfg_reg.official_cap <= 4'd5;
            cfg_reg.min_price    <= 32'd100;
            cfg_reg.max_price    <= 32'd100000000;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                mmws_pkg::REG_TRADE_CAP:    cfg_reg.trade_cap    <= cfg_data[3:0];
                mmws_pkg::REG_QUOTE_CAP:    cfg_reg.quote_cap    <= cfg_data[3:0];
                mmws_pkg::REG_OFFICIAL_CAP: cfg_reg.official_cap <= cfg_data[3:0];
                mmws_pkg::REG_MIN_PRICE:    cfg_reg.min_price    <= cfg_data;
                mmws_pkg::REG_MAX_PRICE:    cfg_reg.max_price    <= cfg_data;
                default: ;
            endcase
        end
    end

    mmws_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .in_end    (s_tlast),
        .win       (win),
        .stage     (stage)
    );

    mmws_check u_check (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .win      (win),
        .stage    (stage),
        .cfg      (cfg_reg),
        .res0     (res0),
        .res1     (res1),
        .push_cnt (push_cnt)
    );

    mmws_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .din0      (res0),
        .din1      (res1),
        .push_cnt  (push_cnt),
        .pop       (pop),
        .dout      (head),
        .not_empty (not_empty),
        .level     (level)
    );

    assign m_tvalid = not_empty;
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last;
    assign m_tdata  = {4'd0, head.officials_seen, head.quotes_seen, head.trades_seen,
                       head.condition, head.size_b, head.price_b, head.size_a,
                       head.price_a, head.ticker, head.stamp};

endmodule

>>> dv/mmws_checker.sv
// Checker for the window scanner: predicts results from the observed traffic and compares.
module mmws_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [7:0]                   s_tdata,
    input  logic                         s_tlast,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [mmws_pkg::TDATA_W-1:0] m_tdata,
    input  logic [1:0]                   m_tuser,
    input  logic                         m_tlast,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [2:0]                   cfg_index,
    input  logic [31:0]                  cfg_data,
    output int                           mismatches,
    output int                           outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import mmws_pkg::*;

    logic [3:0]  cap_trade, cap_quote, cap_official;
    logic [31:0] floor_price, ceil_price;
    logic [7:0]  win [WIN_LEN];
    int          fill;
    logic [3:0]  n_trade, n_quote, n_official;
    res_t        expected_q [$];
    res_t        want;

    initial mismatches = 0;

    function automatic logic [31:0] le32(input int at);
        return {win[at + 3], win[at + 2], win[at + 1], win[at]};
    endfunction

    task automatic clear_packet();
        int i;
        for (i = 0; i < WIN_LEN; i++) win[i] = 8'h00;
        fill = 0;
        n_trade = 4'd0;
        n_quote = 4'd0;
        n_official = 4'd0;
    endtask

    // One payload byte: shift it in, check the full window, close the packet on tlast.
    task automatic scan_byte(input logic [7:0] b, input logic eop);
        res_t        hit;
        res_t        summ;
        logic [63:0] tick;
        logic [31:0] pa, sa, pb, sb;
        logic [7:0]  cond;
        bit          taken, pass;
        int          i, pos;
        for (i = 0; i < WIN_LEN - 1; i++) win[i] = win[i + 1];
        win[WIN_LEN - 1] = b;
        if (fill < WIN_LEN) fill++;
        taken = 0;
        pass  = 0;
        hit   = '0;
        if (fill == WIN_LEN && win[9] >= CHAR_A && win[9] <= CHAR_Z) begin
            case (win[0])
                TYPE_TRADE: if (n_trade < cap_trade) begin
                    n_trade++;
                    taken = 1;
                    hit.kind = KIND_TRADE;
                end
                TYPE_QUOTE: if (n_quote < cap_quote) begin
                    n_quote++;
                    taken = 1;
                    hit.kind = KIND_QUOTE;
                end
                TYPE_OFFICIAL: if (n_official < cap_official) begin
                    n_official++;
                    taken = 1;
                    hit.kind = KIND_OFFICIAL;
                end
                default: ;
            endcase
        end
        if (taken) begin
            tick = '0;
            pos  = 0;
            for (i = 9; i < 17; i++) begin
                if (win[i] > PRINT_LO && win[i] <= PRINT_HI) begin
                    tick = tick | ({56'd0, win[i]} << (8 * pos));
                    pos++;
                end
            end
            pa   = le32(17);
            sa   = le32(21);
            pb   = le32(25);
            sb   = le32(29);
            cond = win[25];
            case (hit.kind)
                KIND_TRADE: begin
                    pass = (pa > floor_price) && (pa < ceil_price);
                    hit.size_a = sa;
                    hit.condition = (cond >= PRINT_LO && cond <= PRINT_HI) ? cond : PRINT_LO;
                end
                KIND_QUOTE: begin
                    pass = (pa > floor_price) && (pb > floor_price) && (pb > pa);
                    hit.size_a  = sa;
                    hit.price_b = pb;
                    hit.size_b  = sb;
                end
                default: pass = pa > floor_price;
            endcase
            if (tick == '0) pass = 0;
            hit.stamp   = {le32(5), le32(1)};
            hit.ticker  = tick;
            hit.price_a = pa;
            hit.last    = !eop;
            if (pass) expected_q.push_back(hit);
        end
        if (eop) begin
            summ = '0;
            summ.kind           = KIND_SUMMARY;
            summ.trades_seen    = n_trade;
            summ.quotes_seen    = n_quote;
            summ.officials_seen = n_official;
            summ.last           = 1'b1;
            expected_q.push_back(summ);
            clear_packet();
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s mismatch: expected %h actual %h", name, exp_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cap_trade    = 4'd10;
            cap_quote    = 4'd5;
            cap_official = 4'd5;
            floor_price  = 32'd100;
            ceil_price   = 32'd100000000;
            clear_packet();
            expected_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_TRADE_CAP:    cap_trade    = cfg_data[3:0];
                    REG_QUOTE_CAP:    cap_quote    = cfg_data[3:0];
                    REG_OFFICIAL_CAP: cap_official = cfg_data[3:0];
                    REG_MIN_PRICE:    floor_price  = cfg_data;
                    REG_MAX_PRICE:    ceil_price   = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result transaction: kind %0d", m_tuser);
                    mismatches++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("kind", 64'(want.kind), 64'(m_tuser));
                    check_field("stamp", want.stamp, m_tdata[63:0]);
                    check_field("ticker", want.ticker, m_tdata[127:64]);
                    check_field("price_a", 64'(want.price_a), 64'(m_tdata[159:128]));
                    check_field("size_a", 64'(want.size_a), 64'(m_tdata[191:160]));
                    check_field("price_b", 64'(want.price_b), 64'(m_tdata[223:192]));
                    check_field("size_b", 64'(want.size_b), 64'(m_tdata[255:224]));
                    check_field("condition", 64'(want.condition), 64'(m_tdata[263:256]));
                    check_field("trades_seen", 64'(want.trades_seen),
                                64'(m_tdata[267:264]));
                    check_field("quotes_seen", 64'(want.quotes_seen),
                                64'(m_tdata[271:268]));
                    check_field("officials_seen", 64'(want.officials_seen),
                                64'(m_tdata[275:272]));
                    check_field("last", 64'(want.last), 64'(m_tlast));
                end
            end
            if (s_tvalid && s_tready) scan_byte(s_tdata, s_tlast);
        end
        outstanding <= expected_q.size();
    end

endmodule

>>> dv/tb.sv
// Testbench top for the window scanner: reset, payload stimulus, config phases, verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mmws_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    localparam logic [63:0] SYM_AB   = 64'h2020_2020_2020_4241;  // "AB" space padded
    localparam logic [63:0] SYM_MIX  = 64'h7F20_4301_2042_2041;  // gaps and unprintables
    localparam logic [63:0] SYM_FULL = 64'h217E_5A5A_5A5A_5A5A;  // eight printable bytes
    localparam logic [63:0] SYM_AT   = 64'h2020_2020_2020_4240;  // first byte below 'A'
    localparam logic [63:0] SYM_BRK  = 64'h2020_2020_2020_425B;  // first byte above 'Z'

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;
    logic               s_tlast;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic [1:0]         m_tuser;
    logic               m_tlast;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;

    int          fails;
    int          pending;
    int          cycle_count;
    int          tx_gap_max = 3;
    int          rx_gap_max = 3;
    int          rx_hold = 0;
    logic [31:0] cur_min = 32'd100;
    logic [31:0] cur_max = 32'd100000000;
    logic [7:0]  pkt_bytes [$];

    market_message_window_scanner uut (.*);

    mmws_checker result_check (
        .*,
        .mismatches (fails),
        .outstanding(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Result sink: random backpressure, plus a long hold-off on request.
    initial begin
        int gap;
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (rx_hold > 0) begin
                gap = rx_hold;
                rx_hold = 0;
            end else begin
                gap = $urandom_range(0, rx_gap_max);
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    function automatic logic [31:0] pick_price();
        logic [32:0] span;
        span = {1'b0, cur_max} - {1'b0, cur_min};
        case ($urandom_range(0, 7))
            0: return cur_min;
            1: return cur_min + 32'd1;
            2: return cur_max;
            3: return cur_max - 32'd1;
            4: return $urandom;
            default: begin
                if (cur_max > cur_min && span > 33'd1)
                    return cur_min + 32'd1 + $urandom_range(0, span[31:0] - 32'd2);
                return $urandom;
            end
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eop);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eop;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_packet();
        int i;
        for (i = 0; i < pkt_bytes.size(); i++)
            send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
        pkt_bytes.delete();
    endtask

    // Sender pause: wait out every expected result, then the pipeline latency.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic program_regs(input logic [3:0] tc, input logic [3:0] qc,
                                input logic [3:0] oc, input logic [31:0] lo,
                                input logic [31:0] hi);
        write_reg(REG_TRADE_CAP, {28'd0, tc});
        write_reg(REG_QUOTE_CAP, {28'd0, qc});
        write_reg(REG_OFFICIAL_CAP, {28'd0, oc});
        write_reg(REG_MIN_PRICE, lo);
        write_reg(REG_MAX_PRICE, hi);
        cfg_valid <= 1'b0;
        cur_min = lo;
        cur_max = hi;
    endtask

    // 36-byte message: type, stamp, symbol, four LE words, three pad bytes.
    task automatic add_msg(input logic [7:0] typ, input logic [63:0] sym,
                           input logic [31:0] pa, input logic [31:0] sa,
                           input logic [31:0] pb, input logic [31:0] sb);
        logic [31:0]  lo_w, hi_w, pad;
        logic [127:0] body;
        int           i;
        lo_w = $urandom;
        hi_w = $urandom;
        pad  = $urandom;
        body = {sb, pb, sa, pa};
        pkt_bytes.push_back(typ);
        for (i = 0; i < 4; i++) pkt_bytes.push_back(lo_w[8*i +: 8]);
        for (i = 0; i < 4; i++) pkt_bytes.push_back(hi_w[8*i +: 8]);
        for (i = 0; i < 8; i++) pkt_bytes.push_back(sym[8*i +: 8]);
        for (i = 0; i < 16; i++) pkt_bytes.push_back(body[8*i +: 8]);
        for (i = 0; i < 3; i++) pkt_bytes.push_back(pad[8*i +: 8]);
    endtask

    task automatic rand_msg();
        logic [63:0] sym;
        logic [31:0] pa, pb, r32;
        logic [7:0]  typ, ch;
        int          i, pick;
        pick = $urandom_range(0, 15);
        r32 = $urandom;
        if (pick < 5) typ = TYPE_TRADE;
        else if (pick < 10) typ = TYPE_QUOTE;
        else if (pick < 14) typ = TYPE_OFFICIAL;
        else typ = r32[7:0];
        for (i = 0; i < 8; i++) begin
            r32 = $urandom;
            case ($urandom_range(0, 9))
                0: ch = r32[7:0];
                1: ch = (i == 0) ? r32[7:0] : PRINT_LO;
                default: ch = CHAR_A + r32[7:0] % 8'd26;
            endcase
            sym[8*i +: 8] = ch;
        end
        pa = pick_price();
        r32 = $urandom;
        if (typ == TYPE_QUOTE) begin
            case ($urandom_range(0, 5))
                0: pb = pa;
                1: pb = pa - 32'd1;
                2: pb = r32;
                default: pb = pa + $urandom_range(1, 5000);
            endcase
        end else if (typ == TYPE_TRADE) begin
            // byte 25 doubles as the sale condition
            pb = r32;
            case ($urandom_range(0, 5))
                0: pb[7:0] = 8'h7F;
                1: pb[7:0] = 8'h1F;
                2: pb[7:0] = PRINT_HI;
                3: ;
                default: pb[7:0] = PRINT_LO + r32[15:8] % 8'd95;
            endcase
        end else begin
            pb = r32;
        end
        add_msg(typ, sym, pa, $urandom, pb, $urandom);
    endtask

    task automatic rand_packet();
        int          mode, n, i, k, cut;
        logic [31:0] r32;
        mode = $urandom_range(0, 9);
        if (mode == 0) begin
            // short packet: a message cut below one window
            rand_msg();
            n = $urandom_range(1, WIN_LEN - 1);
            while (pkt_bytes.size() > n) void'(pkt_bytes.pop_back());
        end else if (mode == 1) begin
            n = $urandom_range(WIN_LEN, 90);
            for (i = 0; i < n; i++) begin
                r32 = $urandom;
                pkt_bytes.push_back(r32[7:0]);
            end
        end else begin
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++) begin
                if ($urandom_range(0, 3) == 0) begin
                    cut = $urandom_range(1, 7);
                    for (i = 0; i < cut; i++) begin
                        r32 = $urandom;
                        pkt_bytes.push_back(r32[7:0]);
                    end
                end
                rand_msg();
            end
            if ($urandom_range(0, 7) == 0) begin
                cut = $urandom_range(1, 20);
                for (i = 0; i < cut; i++) void'(pkt_bytes.pop_back());
            end
        end
    endtask

    initial begin
        int          i, ph, sent;
        logic [31:0] r32;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'h00;
        s_tlast   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_TRADE_CAP;
        cfg_data  <= 32'd0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // one-byte packet: summary only
        pkt_bytes.push_back(TYPE_TRADE);
        send_packet();
        // a trade one byte short of a window
        add_msg(TYPE_TRADE, SYM_AB, 32'd500, 32'd1, 32'h41, 32'd0);
        void'(pkt_bytes.pop_back());
        send_packet();

        // filter edges at the reset settings; the last message ends on tlast
        tx_gap_max = 14;
        rx_gap_max = 14;
        add_msg(TYPE_TRADE, SYM_AB, 32'd101, 32'd500, 32'h41, 32'd0);
        add_msg(TYPE_TRADE, SYM_MIX, 32'd100, 32'd1, 32'h7F, 32'd0);
        add_msg(TYPE_TRADE, SYM_FULL, 32'd99999999, 32'hFFFF_FFFF, 32'h1F, 32'd0);
        add_msg(TYPE_TRADE, SYM_AB, 32'd100000000, 32'd7, 32'h7E, 32'd0);
        add_msg(TYPE_QUOTE, SYM_MIX, 32'd200, 32'd10, 32'd201, 32'd20);
        add_msg(TYPE_QUOTE, SYM_AB, 32'd300, 32'd10, 32'd300, 32'd20);
        add_msg(TYPE_QUOTE, SYM_AB, 32'd100, 32'd10, 32'd5000, 32'd20);
        add_msg(TYPE_OFFICIAL, SYM_FULL, 32'd101, 32'd3, 32'd4, 32'd5);
        add_msg(TYPE_OFFICIAL, SYM_AB, 32'd100, 32'd3, 32'd4, 32'd5);
        add_msg(TYPE_TRADE, SYM_AT, 32'd500, 32'd1, 32'h41, 32'd0);
        add_msg(TYPE_TRADE, SYM_BRK, 32'd500, 32'd1, 32'h41, 32'd0);
        add_msg(8'h55, SYM_AB, 32'd500, 32'd1, 32'h41, 32'd0);
        add_msg(TYPE_TRADE, SYM_FULL, 32'd12345, 32'd9, 32'h20, 32'd0);
        send_packet();

        // caps of one: later matches are ignored
        wait_idle();
        program_regs(4'd1, 4'd1, 4'd1, 32'd100, 32'd100000000);
        for (i = 0; i < 3; i++) add_msg(TYPE_TRADE, SYM_AB, 32'd1000, 32'd1, 32'h41, 32'd0);
        for (i = 0; i < 2; i++) add_msg(TYPE_QUOTE, SYM_AB, 32'd1000, 32'd1, 32'd1001, 32'd2);
        for (i = 0; i < 2; i++) add_msg(TYPE_OFFICIAL, SYM_AB, 32'd1000, 32'd0, 32'd0, 32'd0);
        send_packet();

        // caps of zero with the widest price window
        wait_idle();
        program_regs(4'd0, 4'd0, 4'd0, 32'd0, 32'hFFFF_FFFF);
        add_msg(TYPE_TRADE, SYM_AB, 32'd1000, 32'd1, 32'h41, 32'd0);
        add_msg(TYPE_QUOTE, SYM_AB, 32'd1000, 32'd1, 32'd1001, 32'd2);
        add_msg(TYPE_OFFICIAL, SYM_AB, 32'd1000, 32'd1, 32'd0, 32'd0);
        send_packet();

        // full caps: sixteen trades, the last one past the cap
        wait_idle();
        program_regs(4'd15, 4'd15, 4'd15, 32'd0, 32'hFFFF_FFFF);
        for (i = 0; i < 16; i++) begin
            r32 = (i % 4 == 0) ? 32'd1 : (i % 4 == 1) ? 32'hFFFF_FFFE :
                  (i % 4 == 2) ? 32'hFFFF_FFFF : 32'd0;
            add_msg(TYPE_TRADE, SYM_FULL, r32, 32'd5, 32'h5A, 32'd0);
        end
        add_msg(TYPE_QUOTE, SYM_AB, 32'd0, 32'd1, 32'd10, 32'd2);
        add_msg(TYPE_QUOTE, SYM_AB, 32'd1, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_msg(TYPE_OFFICIAL, SYM_AB, 32'd0, 32'd1, 32'd0, 32'd0);
        add_msg(TYPE_OFFICIAL, SYM_AB, 32'd1, 32'd1, 32'd0, 32'd0);
        send_packet();

        // floor at the top: nothing passes
        wait_idle();
        program_regs(4'd15, 4'd15, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_msg(TYPE_TRADE, SYM_AB, 32'hFFFF_FFFF, 32'd1, 32'h41, 32'd0);
        add_msg(TYPE_QUOTE, SYM_AB, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd2);
        add_msg(TYPE_OFFICIAL, SYM_AB, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd0);
        send_packet();

        // receiver holds off while one-byte packets pile up behind it
        wait_idle();
        program_regs(4'd10, 4'd5, 4'd5, 32'd100, 32'd100000000);
        rx_hold = 300;
        tx_gap_max = 0;
        for (i = 0; i < 40; i++) begin
            r32 = $urandom;
            pkt_bytes.push_back(r32[7:0]);
            send_packet();
        end
        rand_packet();
        send_packet();

        for (ph = 0; ph < 6; ph++) begin
            wait_idle();
            case (ph)
                0: program_regs(4'd10, 4'd5, 4'd5, 32'd100, 32'd100000000);
                1: program_regs(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                                4'($urandom_range(0, 15)), $urandom_range(0, 5000),
                                $urandom_range(32'hFFFF_FFFF, 5000));
                2: program_regs(4'd15, 4'd15, 4'd15, 32'd0, 32'hFFFF_FFFF);
                3: program_regs(4'd0, 4'd15, 4'($urandom_range(1, 3)), 32'd100,
                                32'd100000000);
                4: program_regs(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                                4'($urandom_range(0, 15)), $urandom, $urandom);
                default: program_regs(4'd2, 4'd15, 4'd15, 32'd1000, 32'd2000000);
            endcase
            tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
            rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
            sent = 0;
            while (sent < 60) begin
                rand_packet();
                sent += pkt_bytes.size();
                send_packet();
            end
        end

        wait_idle();
        repeat (10) @(posedge aclk);
        if (fails == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
